// ----- rtl/rth_pkg.sv -----
`timescale 1ns / 1ps

package rth_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned HueW     = 9;
  localparam int unsigned QBits    = 9;   // quotient bits per divider lane
  localparam int unsigned HueNumW  = 17;  // hue numerator, below 360 * 255
  localparam int unsigned SatNumW  = 16;  // 255 * delta
  localparam int unsigned HueAccW  = 19;  // signed working width for the hue numerator
  localparam int unsigned StepW    = 4;   // index of a quotient bit

  localparam int unsigned HueScale    = 60;
  localparam int unsigned HueOffGreen = 120;
  localparam int unsigned HueOffBlue  = 240;
  localparam int unsigned HueWrap     = 360;
  localparam int unsigned FullScale   = 255;

  typedef enum logic [1:0] {
    SelRed,
    SelGreen,
    SelBlue
  } rth_sel_e;

  // One word in flight through the divider: two restoring-division lanes
  // plus lightness riding along.
  typedef struct packed {
    logic [HueNumW-1:0] hue_rem;
    logic [ChanW-1:0]   hue_den;
    logic [QBits-1:0]   hue_q;
    logic [SatNumW-1:0] sat_rem;
    logic [ChanW-1:0]   sat_den;
    logic [QBits-1:0]   sat_q;
    logic [ChanW-1:0]   light;
  } rth_div_t;

  function automatic rth_div_t div_step(rth_div_t s, logic [StepW-1:0] bidx);
    rth_div_t           r;
    logic [HueNumW-1:0] hue_sh;
    logic [SatNumW-1:0] sat_sh;
    r      = s;
    hue_sh = HueNumW'(s.hue_den) << bidx;
    sat_sh = SatNumW'(s.sat_den) << bidx;
    if (s.hue_rem >= hue_sh) begin
      r.hue_rem     = s.hue_rem - hue_sh;
      r.hue_q[bidx] = 1'b1;
    end
    if (s.sat_rem >= sat_sh) begin
      r.sat_rem     = s.sat_rem - sat_sh;
      r.sat_q[bidx] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/rth_pixel_if.sv -----
`timescale 1ns / 1ps

interface rth_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [rth_pkg::ChanW-1:0] red_in;
  logic [rth_pkg::ChanW-1:0] green_in;
  logic [rth_pkg::ChanW-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// ----- rtl/rth_hsl_if.sv -----
`timescale 1ns / 1ps

interface rth_hsl_if;
  logic                      valid;
  logic                      ready;
  logic [rth_pkg::HueW-1:0]  hue_deg;
  logic [rth_pkg::ChanW-1:0] saturation;
  logic [rth_pkg::ChanW-1:0] lightness;

  modport source (output valid, output hue_deg, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue_deg, input saturation, input lightness,
                  output ready);
endinterface

// ----- rtl/rth_front.sv -----
`timescale 1ns / 1ps

// Two stages: max/min sort, then build the dividends and divisors.
module rth_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rth_pkg::ChanW-1:0]   red_i,
  input  logic [rth_pkg::ChanW-1:0]   green_i,
  input  logic [rth_pkg::ChanW-1:0]   blue_i,
  output logic                        valid_o,
  output rth_pkg::rth_div_t           op_o
);

  // stage 1
  logic                        s1_valid_q;
  logic [rth_pkg::ChanW-1:0]   delta_q, delta_d;
  logic [rth_pkg::ChanW-1:0]   sden_q, sden_d;
  logic [rth_pkg::ChanW-1:0]   light_q, light_d;
  logic signed [rth_pkg::ChanW:0] diff_q, diff_d;
  rth_pkg::rth_sel_e           sel_q, sel_d;

  logic [rth_pkg::ChanW-1:0] mx, mn;
  logic [rth_pkg::ChanW:0]   sum;

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sel_d  = rth_pkg::SelRed;
      mx     = red_i;
      diff_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sel_d  = rth_pkg::SelGreen;
      mx     = green_i;
      diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sel_d  = rth_pkg::SelBlue;
      mx     = blue_i;
      diff_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    sum     = {1'b0, mx} + {1'b0, mn};
    delta_d = mx - mn;
    light_d = sum[rth_pkg::ChanW:1];
    if (sum <= (rth_pkg::ChanW+1)'(rth_pkg::FullScale)) begin
      sden_d = sum[rth_pkg::ChanW-1:0];
    end else begin
      sden_d = rth_pkg::ChanW'((rth_pkg::ChanW+1)'(2 * rth_pkg::FullScale) - sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      delta_q <= delta_d;
      sden_q  <= sden_d;
      light_q <= light_d;
      diff_q  <= diff_d;
      sel_q   <= sel_d;
    end
  end

  // stage 2
  logic                         s2_valid_q;
  rth_pkg::rth_div_t            op_q, op_d;
  logic signed [rth_pkg::HueAccW-1:0] diff_ext, acc;
  logic [rth_pkg::HueNumW-1:0]  off_term, wrap_term;

  always_comb begin
    diff_ext  = {{(rth_pkg::HueAccW-rth_pkg::ChanW-1){diff_q[rth_pkg::ChanW]}}, diff_q};
    case (sel_q)
      rth_pkg::SelGreen: off_term = rth_pkg::HueNumW'(delta_q * rth_pkg::HueNumW'(rth_pkg::HueOffGreen));
      rth_pkg::SelBlue:  off_term = rth_pkg::HueNumW'(delta_q * rth_pkg::HueNumW'(rth_pkg::HueOffBlue));
      default:           off_term = '0;
    endcase
    wrap_term = rth_pkg::HueNumW'(delta_q * rth_pkg::HueNumW'(rth_pkg::HueWrap));
    acc = rth_pkg::HueAccW'(diff_ext * $signed(rth_pkg::HueAccW'(rth_pkg::HueScale)))
        + $signed({2'b00, off_term});
    // only the red sector can go negative
    if (acc[rth_pkg::HueAccW-1]) begin
      acc = acc + $signed({2'b00, wrap_term});
    end

    op_d       = '0;
    op_d.light = light_q;
    if (delta_q == '0) begin
      // gray: zero dividends over unit divisors give hue and saturation of zero
      op_d.hue_den = rth_pkg::ChanW'(1);
      op_d.sat_den = rth_pkg::ChanW'(1);
    end else begin
      op_d.hue_rem = acc[rth_pkg::HueNumW-1:0];
      op_d.hue_den = delta_q;
      op_d.sat_rem = {delta_q, {rth_pkg::ChanW{1'b0}}} - rth_pkg::SatNumW'(delta_q);
      op_d.sat_den = sden_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign op_o    = op_q;

endmodule

// ----- rtl/rth_divider.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, hue and
// saturation lanes side by side.
module rth_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rth_pkg::rth_div_t op_i,
  output logic              valid_o,
  output rth_pkg::rth_div_t res_o
);

  logic              vld_q [rth_pkg::QBits+1];
  rth_pkg::rth_div_t stg_q [rth_pkg::QBits+1];

  assign vld_q[0] = valid_i;
  assign stg_q[0] = op_i;

  for (genvar k = 0; k < rth_pkg::QBits; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    // msb first
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k+1] <= rth_pkg::div_step(stg_q[k],
                                        rth_pkg::StepW'(rth_pkg::QBits - 1 - k));
      end
    end
  end

  assign valid_o = vld_q[rth_pkg::QBits];
  assign res_o   = stg_q[rth_pkg::QBits];

endmodule

// ----- rtl/rgb_to_hsl_converter.sv -----
`timescale 1ns / 1ps

// RGB to HSL pixel converter.
// pix_i takes one word per cycle while pix_i.ready is high: 8-bit red_in, green_in, blue_in.
// hsl_o gives one word per pixel, in order: hue_deg (0..359 degrees),
// saturation and lightness (255 = 1.0), all truncated.
// Both channels use valid/ready; a word moves when both are high.
// From input accept to output valid the path is two stages of
// sort and operand setup, then nine divider stages, one quotient bit each.
// Throughput is one pixel per clock while hsl_o does not stall.
// The whole pipeline advances together whenever the output register is
// empty or being taken; if hsl_o stalls with a word held, every stage holds
// and pix_i.ready drops in the same cycle, so nothing is lost or repeated.
// Bubbles travel as cleared valid bits.
// Reset (rst_ni low, asynchronous) clears all valid bits; the block comes
// out of reset empty and ready.
module rgb_to_hsl_converter (
  input  logic         clk_i,
  input  logic         rst_ni,
  rth_pixel_if.sink    pix_i,
  rth_hsl_if.source    hsl_o
);

  logic              en;
  logic              fr_valid, dv_valid;
  rth_pkg::rth_div_t fr_op, dv_res;

  assign en          = !dv_valid || hsl_o.ready;
  assign pix_i.ready = en;

  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red_in),
    .green_i (pix_i.green_in),
    .blue_i  (pix_i.blue_in),
    .valid_o (fr_valid),
    .op_o    (fr_op)
  );

  rth_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .op_i    (fr_op),
    .valid_o (dv_valid),
    .res_o   (dv_res)
  );

  assign hsl_o.valid      = dv_valid;
  assign hsl_o.hue_deg    = dv_res.hue_q;
  assign hsl_o.saturation = dv_res.sat_q[rth_pkg::ChanW-1:0];
  assign hsl_o.lightness  = dv_res.light;

endmodule

// ----- rtl/rth_checker.sv -----
`timescale 1ns / 1ps

module rth_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rth_pkg::HueW-1:0]  hue_i,
  input logic [rth_pkg::ChanW-1:0] sat_i,
  input logic [rth_pkg::ChanW-1:0] light_i
);

  // held word must stay put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(hue_i) && $stable(sat_i)
                                    && $stable(light_i))
    else $error("output word changed while stalled");

  // an empty output always lets the pipe move
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // input backpressure only comes from a held output word
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output stall");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> hue_i < rth_pkg::HueW'(rth_pkg::HueWrap))
    else $error("hue out of range");

endmodule

bind rgb_to_hsl_converter rth_checker u_rth_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (hsl_o.valid),
  .out_ready_i (hsl_o.ready),
  .hue_i       (hsl_o.hue_deg),
  .sat_i       (hsl_o.saturation),
  .light_i     (hsl_o.lightness)
);
